// ===== design/fcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fcmt_pkg: shared types and microcode for the multiset table
// Opcodes, sequencer step codes, control word and status layouts, and the
// read-only control store that the sequencer steps through.
// ----------------------------------------------------------------------------
package fcmt_pkg;

  localparam int CAPACITY_ITEMS_DEF = 32;
  localparam int VALUE_BITS_DEF     = 32;

  localparam int OPCODE_W    = 2;
  localparam int ITEM_W      = 32;
  localparam int CNT_FIELD_W = 6;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_INSERT      = 2'd0,
    OP_ERASE_ALL   = 2'd1,
    OP_ERASE_FIRST = 2'd2,
    OP_COUNT       = 2'd3
  } opcode_e;

  // Steps of the control program.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_INS  = 3'd1,
    ST_SCAN = 3'd2,
    ST_CMP  = 3'd3,
    ST_MOVE = 3'd4,
    ST_DONE = 3'd5
  } step_e;

  // Datapath action of one step.
  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_READ    = 3'd2,
    ACT_COMPARE = 3'd3,
    ACT_MOVE    = 3'd4,
    ACT_EMIT    = 3'd5
  } act_e;

  // Branch condition of one step; each picks hold, target A or target B.
  typedef enum logic [2:0] {
    C_START   = 3'd0,
    C_ALWAYS  = 3'd1,
    C_EMPTY   = 3'd2,
    C_COMPARE = 3'd3,
    C_MOVE    = 3'd4,
    C_OUT     = 3'd5
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e tgt_a;
    step_e tgt_b;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic start_insert;
    logic scan_empty;
    logic erase_hit;
    logic scan_last;
    logic erase_first;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    case (step)
      ST_IDLE: w = '{act: ACT_LOAD,    cond: C_START,   tgt_a: ST_INS,  tgt_b: ST_SCAN};
      ST_INS:  w = '{act: ACT_INSERT,  cond: C_ALWAYS,  tgt_a: ST_DONE, tgt_b: ST_DONE};
      ST_SCAN: w = '{act: ACT_READ,    cond: C_EMPTY,   tgt_a: ST_DONE, tgt_b: ST_CMP};
      ST_CMP:  w = '{act: ACT_COMPARE, cond: C_COMPARE, tgt_a: ST_MOVE, tgt_b: ST_DONE};
      ST_MOVE: w = '{act: ACT_MOVE,    cond: C_MOVE,    tgt_a: ST_DONE, tgt_b: ST_SCAN};
      ST_DONE: w = '{act: ACT_EMIT,    cond: C_OUT,     tgt_a: ST_IDLE, tgt_b: ST_IDLE};
      default: w = '{act: ACT_LOAD,    cond: C_START,   tgt_a: ST_INS,  tgt_b: ST_SCAN};
    endcase
    return w;
  endfunction

endpackage

// ===== design/fixed_capacity_multiset_table.sv =====
// ----------------------------------------------------------------------------
// fixed_capacity_multiset_table: unordered multiset of up to CAPACITY_ITEMS
// Insert, erase-one, erase-all and count over a compact slot store, run by a
// small microcoded sequencer; one result item per request item.
// ----------------------------------------------------------------------------
// The block holds its entries in slots 0 to fill-1 of a single-port-read RAM
// and handles one request at a time. Count and erase-all scan all fill slots,
// comparing one slot per cycle through the RAM read port while no entry is
// removed; each entry removed by erase-all inserts a fetch of the last entry,
// then a re-read of the refilled slot. Erase-one stops at the first match.
// A new request is accepted once the previous result sits in the output
// register, even if it is not yet taken. The slot store needs no clearing
// after reset. An insert into a full store reports full_error and changes
// nothing.
module fixed_capacity_multiset_table #(
  parameter int CAPACITY_ITEMS = fcmt_pkg::CAPACITY_ITEMS_DEF,
  parameter int VALUE_BITS     = fcmt_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] item_value (signed)
  input  logic signed [fcmt_pkg::ITEM_W-1:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [fcmt_pkg::OPCODE_W-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [5:0] match_count, [6] found, [7] full_error, [13:8] fill_level, [15:14] zero
  output logic [fcmt_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  fcmt_pkg::ctrl_t ctrl;
  fcmt_pkg::stat_t stat;

  fcmt_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  fcmt_datapath #(
    .CAPACITY_ITEMS (CAPACITY_ITEMS),
    .VALUE_BITS     (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // One request at a time: right after an accepted item the block is busy.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // A refused insert only happens with the store at capacity.
  a_full_error_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[7]) |->
      (m_axis_tdata_o[13:8] == fcmt_pkg::CNT_FIELD_W'(CAPACITY_ITEMS)))
    else $error("full_error reported below capacity");

  // found belongs to erase-one alone, which reports no count and no error.
  a_found_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[6]) |->
      (m_axis_tdata_o[5:0] == '0 && !m_axis_tdata_o[7]))
    else $error("found reported together with a count or an error");
`endif

endmodule

// ===== design/fcmt_ram.sv =====
// ----------------------------------------------------------------------------
// fcmt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fcmt_sequencer.sv =====
// ----------------------------------------------------------------------------
// fcmt_sequencer: microcode sequencer of the multiset table
// Holds the step counter, fetches the control word and resolves the branch.
// ----------------------------------------------------------------------------
module fcmt_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcmt_pkg::stat_t stat_i,
  output fcmt_pkg::ctrl_t ctrl_o
);

  fcmt_pkg::step_e pc_q, pc_d;
  fcmt_pkg::ctrl_t word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fcmt_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    word = fcmt_pkg::ucode(pc_q);
    pc_d = pc_q;
    case (word.cond)
      fcmt_pkg::C_START: begin
        if (stat_i.in_fire) begin
          pc_d = stat_i.start_insert ? word.tgt_a : word.tgt_b;
        end
      end
      fcmt_pkg::C_ALWAYS: begin
        pc_d = word.tgt_a;
      end
      fcmt_pkg::C_EMPTY: begin
        pc_d = stat_i.scan_empty ? word.tgt_a : word.tgt_b;
      end
      fcmt_pkg::C_COMPARE: begin
        // Stay on this step while slots stream past without a removal.
        if (stat_i.erase_hit) begin
          pc_d = word.tgt_a;
        end else if (stat_i.scan_last) begin
          pc_d = word.tgt_b;
        end
      end
      fcmt_pkg::C_MOVE: begin
        pc_d = stat_i.erase_first ? word.tgt_a : word.tgt_b;
      end
      fcmt_pkg::C_OUT: begin
        if (!stat_i.out_busy) begin
          pc_d = word.tgt_a;
        end
      end
      default: begin
        pc_d = fcmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctrl_o = word;

endmodule

// ===== design/fcmt_datapath.sv =====
// ----------------------------------------------------------------------------
// fcmt_datapath: slot store, scan registers and result register
// Executes the action of each control word and reports branch status.
// ----------------------------------------------------------------------------
module fcmt_datapath #(
  parameter int CAPACITY_ITEMS = fcmt_pkg::CAPACITY_ITEMS_DEF,
  parameter int VALUE_BITS     = fcmt_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fcmt_pkg::ctrl_t                        ctrl_i,
  output fcmt_pkg::stat_t                        stat_o,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic signed [fcmt_pkg::ITEM_W-1:0]     s_axis_tdata_i,
  input  logic [fcmt_pkg::OPCODE_W-1:0]          s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [fcmt_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o
);

  localparam int IW = $clog2(CAPACITY_ITEMS + 1);
  localparam int AW = (CAPACITY_ITEMS > 1) ? $clog2(CAPACITY_ITEMS) : 1;
  localparam int CW = fcmt_pkg::CNT_FIELD_W;

  fcmt_pkg::opcode_e     op_q, op_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         fill_q, fill_d;
  logic [IW-1:0]         cnt_q, cnt_d;
  logic                  hit_q, hit_d;
  logic                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [fcmt_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [IW-1:0] idx_nxt;
  logic [IW-1:0] fill_dec;
  logic          in_fire;
  logic          is_erase;
  logic          slot_match;
  logic          store_full;
  logic          out_busy;

  fcmt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY_ITEMS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (ctrl_i.act == fcmt_pkg::ACT_LOAD);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_nxt         = idx_q + IW'(1);
  assign fill_dec        = fill_q - IW'(1);
  assign is_erase        = (op_q == fcmt_pkg::OP_ERASE_ALL) ||
                           (op_q == fcmt_pkg::OP_ERASE_FIRST);
  assign slot_match      = (ram_rdata == val_q);
  assign store_full      = (fill_q >= IW'(CAPACITY_ITEMS));
  assign out_busy        = out_valid_q && !m_axis_tready_i;

  always_comb begin
    stat_o.in_fire      = in_fire;
    stat_o.start_insert = (fcmt_pkg::opcode_e'(s_axis_tuser_i) == fcmt_pkg::OP_INSERT);
    stat_o.scan_empty   = (idx_q >= fill_q);
    stat_o.erase_hit    = slot_match && is_erase;
    stat_o.scan_last    = (idx_nxt >= fill_q);
    stat_o.erase_first  = (op_q == fcmt_pkg::OP_ERASE_FIRST);
    stat_o.out_busy     = out_busy;
  end

  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    err_d       = err_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[AW-1:0];
    case (ctrl_i.act)
      fcmt_pkg::ACT_LOAD: begin
        if (in_fire) begin
          op_d  = fcmt_pkg::opcode_e'(s_axis_tuser_i);
          val_d = VALUE_BITS'($unsigned(s_axis_tdata_i));
          idx_d = '0;
          cnt_d = '0;
          hit_d = 1'b0;
          err_d = 1'b0;
        end
      end
      fcmt_pkg::ACT_INSERT: begin
        if (store_full) begin
          err_d = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = fill_q[AW-1:0];
          ram_wdata = val_q;
          fill_d    = fill_q + IW'(1);
        end
      end
      fcmt_pkg::ACT_READ: begin
        ram_raddr = idx_q[AW-1:0];
      end
      fcmt_pkg::ACT_COMPARE: begin
        if (slot_match && is_erase) begin
          // Fetch the last entry; it fills the matched slot in the next step.
          fill_d    = fill_dec;
          ram_raddr = fill_dec[AW-1:0];
        end else begin
          if (slot_match) begin
            cnt_d = cnt_q + IW'(1);
          end
          idx_d     = idx_nxt;
          ram_raddr = idx_nxt[AW-1:0];
        end
      end
      fcmt_pkg::ACT_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (op_q == fcmt_pkg::OP_ERASE_FIRST) begin
          hit_d = 1'b1;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      fcmt_pkg::ACT_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, CW'(fill_q), err_q, hit_q, CW'(cnt_q)};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= fcmt_pkg::OP_INSERT;
      idx_q       <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      op_q        <= op_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== tb/fcmt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcmt_checker: result checker for the multiset table
// Watches both stream channels, keeps its own copy of the slot store, works
// out the reply for every accepted request and compares each accepted reply
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module fcmt_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  logic                              req_ready_i,
  input  logic [fcmt_pkg::ITEM_W-1:0]       req_value_i,
  input  logic [fcmt_pkg::OPCODE_W-1:0]     req_opcode_i,
  input  logic                              rsp_valid_i,
  input  logic                              rsp_ready_i,
  input  logic [fcmt_pkg::OUT_DATA_W-1:0]   rsp_data_i,
  output int unsigned                       replies_pending_o,
  output int unsigned                       fail_count_o
);

  localparam int CAP = fcmt_pkg::CAPACITY_ITEMS_DEF;
  localparam int VW  = fcmt_pkg::VALUE_BITS_DEF;
  localparam int CW  = fcmt_pkg::CNT_FIELD_W;

  // Laid out as on the reply bus, match_count in the lowest bits.
  typedef struct packed {
    logic [CW-1:0] fill_level;
    logic          full_error;
    logic          found;
    logic [CW-1:0] match_count;
  } reply_t;

  logic [VW-1:0] bag_slots [CAP];
  int unsigned   bag_fill;
  reply_t        reply_q [$];
  int unsigned   mismatches;
  reply_t        want;
  reply_t        got;

  // Applies one request to the shadow store and returns the reply it causes.
  function automatic reply_t bag_apply(fcmt_pkg::opcode_e op, logic [VW-1:0] val);
    reply_t      r;
    int unsigned idx;
    int unsigned hits;
    bit          done;
    r    = '0;
    hits = 0;
    done = 1'b0;
    case (op)
      fcmt_pkg::OP_INSERT: begin
        if (bag_fill >= CAP) begin
          r.full_error = 1'b1;
        end else begin
          bag_slots[bag_fill] = val;
          bag_fill++;
        end
      end
      fcmt_pkg::OP_ERASE_ALL: begin
        idx = 0;
        // The refilled slot must be compared again before moving on.
        while (idx < bag_fill) begin
          if (bag_slots[idx] == val) begin
            bag_fill--;
            bag_slots[idx] = bag_slots[bag_fill];
            hits++;
          end else begin
            idx++;
          end
        end
      end
      fcmt_pkg::OP_ERASE_FIRST: begin
        for (idx = 0; idx < bag_fill && !done; idx++) begin
          if (bag_slots[idx] == val) begin
            bag_fill--;
            bag_slots[idx] = bag_slots[bag_fill];
            done = 1'b1;
          end
        end
        r.found = done;
      end
      default: begin
        for (idx = 0; idx < bag_fill; idx++) begin
          if (bag_slots[idx] == val) hits++;
        end
      end
    endcase
    r.match_count = hits[CW-1:0];
    r.fill_level  = bag_fill[CW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bag_fill = 0;
      mismatches = 0;
      reply_q.delete();
      replies_pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        reply_q.push_back(bag_apply(fcmt_pkg::opcode_e'(req_opcode_i),
                                    req_value_i[VW-1:0]));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_data_i[$bits(reply_t)-1:0];
        if (reply_q.size() == 0) begin
          $error("reply item 0x%h arrived with no request outstanding", rsp_data_i);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("match_count", 32'(want.match_count), 32'(got.match_count));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("full_error", 32'(want.full_error), 32'(got.full_error));
          check_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
        end
      end
      replies_pending_o <= reply_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the multiset table
// Drives directed requests, then random traffic in three handshake phases,
// the first two with back-pressure on both channels; the checker beside the
// block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAP        = fcmt_pkg::CAPACITY_ITEMS_DEF;
  localparam int POOL_SIZE  = 8;
  localparam int PHASE_REQS = 125;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [fcmt_pkg::ITEM_W-1:0]     s_tdata = '0;
  logic [fcmt_pkg::OPCODE_W-1:0]   s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [fcmt_pkg::OUT_DATA_W-1:0] m_tdata;
  int unsigned                     replies_pending;
  int unsigned                     fail_count;

  int unsigned                     valid_idle_pct = 0;
  int unsigned                     ready_idle_pct = 0;
  int unsigned                     reqs_sent = 0;
  logic [fcmt_pkg::ITEM_W-1:0]     value_pool [POOL_SIZE];

  always #5 clk = ~clk;

  fixed_capacity_multiset_table DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fcmt_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .req_valid_i       (s_tvalid),
    .req_ready_i       (s_tready),
    .req_value_i       (s_tdata),
    .req_opcode_i      (s_tuser),
    .rsp_valid_i       (m_tvalid),
    .rsp_ready_i       (m_tready),
    .rsp_data_i        (m_tdata),
    .replies_pending_o (replies_pending),
    .fail_count_o      (fail_count)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= ready_idle_pct);
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_req(fcmt_pkg::opcode_e op, logic [fcmt_pkg::ITEM_W-1:0] val);
    while ($urandom_range(99) < valid_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    reqs_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  // Empties the store (it only ever holds pool values here), fills it with one
  // value, overflows it, then counts and removes that value.
  task automatic flood_store();
    logic [fcmt_pkg::ITEM_W-1:0] v;
    v = value_pool[$urandom_range(POOL_SIZE-1)];
    for (int i = 0; i < POOL_SIZE; i++) send_req(fcmt_pkg::OP_ERASE_ALL, value_pool[i]);
    for (int i = 0; i < CAP + 2; i++) send_req(fcmt_pkg::OP_INSERT, v);
    send_req(fcmt_pkg::OP_COUNT, v);
    send_req(fcmt_pkg::OP_ERASE_FIRST, v);
    send_req(fcmt_pkg::OP_COUNT, v);
    send_req(fcmt_pkg::OP_ERASE_ALL, v);
  endtask

  task automatic random_req();
    fcmt_pkg::opcode_e           op;
    logic [fcmt_pkg::ITEM_W-1:0] v;
    bit                          insert_heavy;
    // Alternate between blocks that grow the store and blocks that shrink it.
    insert_heavy = ((reqs_sent / 50) % 2) == 0;
    if ($urandom_range(99) < (insert_heavy ? 75 : 25)) begin
      op = fcmt_pkg::OP_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       op = fcmt_pkg::OP_ERASE_ALL;
        1:       op = fcmt_pkg::OP_ERASE_FIRST;
        default: op = fcmt_pkg::OP_COUNT;
      endcase
    end
    // Inserts stay within the pool so that a flood can always clear the store.
    if (op == fcmt_pkg::OP_INSERT || $urandom_range(99) < 80) begin
      v = value_pool[$urandom_range(POOL_SIZE-1)];
    end else begin
      v = $urandom;
    end
    send_req(op, v);
  endtask

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extreme values, duplicates, misses, last-slot erase.
    send_req(fcmt_pkg::OP_COUNT,       32'h0000_0000);
    send_req(fcmt_pkg::OP_ERASE_FIRST, 32'h0000_0000);
    send_req(fcmt_pkg::OP_ERASE_ALL,   32'h0000_0000);
    send_req(fcmt_pkg::OP_INSERT,      32'h7FFF_FFFF);
    send_req(fcmt_pkg::OP_INSERT,      32'h8000_0000);
    send_req(fcmt_pkg::OP_INSERT,      32'hFFFF_FFFF);
    send_req(fcmt_pkg::OP_INSERT,      32'h0000_0000);
    send_req(fcmt_pkg::OP_INSERT,      32'h5555_5555);
    send_req(fcmt_pkg::OP_INSERT,      32'hAAAA_AAAA);
    send_req(fcmt_pkg::OP_INSERT,      32'h8000_0000);
    send_req(fcmt_pkg::OP_COUNT,       32'h8000_0000);
    send_req(fcmt_pkg::OP_COUNT,       32'h1234_5678);
    send_req(fcmt_pkg::OP_ERASE_FIRST, 32'h7FFF_FFFF);
    send_req(fcmt_pkg::OP_ERASE_FIRST, 32'hDEAD_BEEF);
    send_req(fcmt_pkg::OP_ERASE_ALL,   32'h8000_0000);
    send_req(fcmt_pkg::OP_ERASE_ALL,   32'hCAFE_F00D);
    send_req(fcmt_pkg::OP_ERASE_FIRST, 32'hAAAA_AAAA);
    send_req(fcmt_pkg::OP_ERASE_ALL,   32'hFFFF_FFFF);
    send_req(fcmt_pkg::OP_ERASE_FIRST, 32'h0000_0000);
    send_req(fcmt_pkg::OP_ERASE_ALL,   32'h5555_5555);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          valid_idle_pct = 34;
          ready_idle_pct = 46;
        end
        1: begin
          valid_idle_pct = 46;
          ready_idle_pct = 34;
        end
        default: begin
          valid_idle_pct = 0;
          ready_idle_pct = 0;
        end
      endcase
      flood_store();
      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(99) == 0) flood_store();
        else random_req();
      end
      wait_drained();
    end

    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
